// ----- rtl/core/lre_pkg.sv -----
// Shared types, constants and helper functions for the left-to-right
// expression evaluator. No dependencies.
package lre_pkg;

    localparam int DATA_WIDTH   = 32;
    localparam int RESULT_WIDTH = 32;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W        = $clog2(DATA_WIDTH);

    typedef logic [DATA_WIDTH-1:0] t_value;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } t_op;

    typedef enum logic [2:0] {
        K_DIGIT,
        K_SPACE,
        K_OTHER,
        K_OP,
        K_EQ
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [3:0] digit;
        t_op        op;
    } t_item;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // Sort one input item into the class the back end acts on.
    function automatic t_item classify(logic cmd, logic [7:0] ch);
        t_item it;
        it.kind  = K_OTHER;
        it.digit = ch[3:0];
        it.op    = OP_NONE;
        if (cmd) begin
            it.kind = K_EQ;
        end else begin
            case (ch)
                CH_PLUS:  begin it.kind = K_OP; it.op = OP_ADD; end
                CH_MINUS: begin it.kind = K_OP; it.op = OP_SUB; end
                CH_STAR:  begin it.kind = K_OP; it.op = OP_MUL; end
                CH_SLASH: begin it.kind = K_OP; it.op = OP_DIV; end
                default: begin
                    if (ch >= CH_ZERO && ch <= CH_NINE) begin
                        it.kind = K_DIGIT;
                    end else if (ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR)) begin
                        it.kind = K_SPACE;
                    end else begin
                        it.kind = K_OTHER;
                    end
                end
            endcase
        end
        return it;
    endfunction

    // Sign-extend or truncate a working value to the result width.
    function automatic logic signed [RESULT_WIDTH-1:0] to_result(t_value v);
        return RESULT_WIDTH'(signed'(v));
    endfunction

endpackage

// ----- rtl/core/left_to_right_expression_evaluator_top.sv -----
// Top level of the left-to-right expression evaluator.
// Depends on lre_pkg, lre_front, lre_fifo and lre_back.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall): one item per handshake, either
//   an expression character (i_cmd = 0, ASCII in i_char_code) or equals
//   (i_cmd = 1). Digits build a decimal number; + - * / combine the running
//   value with that number strictly left to right, no precedence.
//   Output channel (o_out_valid / i_out_stall): one signed 32-bit item in
//   o_result for each equals; after it all state is cleared.
//   Timing: the front end classifies each item into a four-entry queue and
//   the back end drains it. Characters, + - * and equals after + - * are
//   handled in the idle state; equals waits there while a stalled result is
//   pending, and its result is registered when it is taken. An operator or
//   equals that closes a division runs the one-bit-per-cycle restoring
//   divider (S_DIV, then S_FIX), and equals then passes S_EMIT to emit.
//   Division by zero gives 0; the most negative value over -1 wraps.
//   Reset (synchronous, active low) empties the queue, clears the FSM state,
//   value, number and operator, and drops the result valid.
//   While the receiver stalls, hold the result; the back end keeps working
//   on characters, and the queue still takes items until it is full.
module left_to_right_expression_evaluator_top (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic                                    i_cmd,
    input  logic [7:0]                              i_char_code,
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic signed [lre_pkg::RESULT_WIDTH-1:0] o_result
);
    import lre_pkg::*;

    t_item     push_item;
    t_item     head_item;
    t_q_status q_status;
    logic      push;
    logic      pop;

    // Classify and push accepted items.
    lre_front u_front (
        .i_in_valid  (i_in_valid),
        .i_cmd       (i_cmd),
        .i_char_code (i_char_code),
        .i_q_status  (q_status),
        .o_in_stall  (o_in_stall),
        .o_push      (push),
        .o_item      (push_item)
    );

    // Decouple the front end from the slow back end.
    lre_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (push_item),
        .i_pop    (pop),
        .o_item   (head_item),
        .o_status (q_status)
    );

    // Execute items and hold the result register.
    lre_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (head_item),
        .i_q_status  (q_status),
        .o_pop       (pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_result    (o_result)
    );

endmodule

// ----- rtl/core/lre_front.sv -----
// Front end: takes input items and classifies them for the queue.
// Depends on lre_pkg.
module lre_front (
    input  logic               i_in_valid,
    input  logic               i_cmd,
    input  logic [7:0]         i_char_code,
    input  lre_pkg::t_q_status i_q_status,
    output logic               o_in_stall,
    output logic               o_push,
    output lre_pkg::t_item     o_item
);
    import lre_pkg::*;

    // Stall while the queue is full; push every accepted item.
    assign o_in_stall = i_q_status.full;
    assign o_push     = i_in_valid && !i_q_status.full;
    assign o_item     = classify(i_cmd, i_char_code);

endmodule

// ----- rtl/core/lre_fifo.sv -----
// Short queue of classified items between front and back end.
// Depends on lre_pkg.
module lre_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  lre_pkg::t_item     i_item,
    input  logic               i_pop,
    output lre_pkg::t_item     o_item,
    output lre_pkg::t_q_status o_status
);
    import lre_pkg::*;

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QPTR_W:0]   r_count,  n_count;
    logic              do_push, do_pop;

    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_item         = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ----- rtl/core/lre_back.sv -----
// Back end: number building, operator execution, iterative divider and
// the result register. Depends on lre_pkg.
module lre_back (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  lre_pkg::t_item                         i_item,
    input  lre_pkg::t_q_status                     i_q_status,
    output logic                                   o_pop,
    input  logic                                   i_out_stall,
    output logic                                   o_out_valid,
    output logic signed [lre_pkg::RESULT_WIDTH-1:0] o_result
);
    import lre_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_FIX,
        S_EMIT
    } t_state;

    t_state     r_state,   n_state;
    t_value     r_left,    n_left;
    t_value     r_num,     n_num;
    t_op        r_op,      n_op;
    logic       r_started, n_started;
    logic       r_ended,   n_ended;
    logic       r_is_eq,   n_is_eq;
    logic       r_neg,     n_neg;
    logic       r_den_zero, n_den_zero;
    t_value     r_rem,     n_rem;
    t_value     r_quo,     n_quo;
    t_value     r_den,     n_den;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic       r_out_valid, n_out_valid;
    logic signed [RESULT_WIDTH-1:0] r_out_result, n_out_result;

    t_value               apply_val;
    t_value               prod;
    t_value               left_mag, num_mag;
    t_value               num_x10;
    logic [DATA_WIDTH:0]  rem_sh;
    logic [DATA_WIDTH:0]  diff;
    t_value               quo_fix;
    logic                 out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out_result;

    assign prod     = r_left * r_num;
    assign left_mag = r_left[DATA_WIDTH-1] ? t_value'(-r_left) : r_left;
    assign num_mag  = r_num[DATA_WIDTH-1]  ? t_value'(-r_num)  : r_num;
    assign num_x10  = t_value'({r_num, 3'b000}) + t_value'({r_num, 1'b0});
    assign rem_sh   = {r_rem, r_quo[DATA_WIDTH-1]};
    assign diff     = rem_sh - {1'b0, r_den};
    assign quo_fix  = r_den_zero ? '0 : (r_neg ? t_value'(-r_quo) : r_quo);

    always_comb begin
        case (r_op)
            OP_ADD:  apply_val = r_left + r_num;
            OP_SUB:  apply_val = r_left - r_num;
            OP_MUL:  apply_val = prod;
            default: apply_val = r_num;
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_left       = r_left;
        n_num        = r_num;
        n_op         = r_op;
        n_started    = r_started;
        n_ended      = r_ended;
        n_is_eq      = r_is_eq;
        n_neg        = r_neg;
        n_den_zero   = r_den_zero;
        n_rem        = r_rem;
        n_quo        = r_quo;
        n_den        = r_den;
        n_cnt        = r_cnt;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_result = r_out_result;
        o_pop        = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (!i_q_status.empty) begin
                    case (i_item.kind)
                        K_DIGIT: begin
                            o_pop = 1'b1;
                            if (!r_ended) begin
                                n_num     = num_x10 + t_value'(i_item.digit);
                                n_started = 1'b1;
                            end
                        end
                        K_SPACE: begin
                            o_pop = 1'b1;
                            if (r_started) begin
                                n_ended = 1'b1;
                            end
                        end
                        K_OTHER: begin
                            o_pop   = 1'b1;
                            n_ended = 1'b1;
                        end
                        K_OP, K_EQ: begin
                            if (r_op == OP_DIV) begin
                                // Start the divider on magnitudes; fix the sign at the end.
                                o_pop      = 1'b1;
                                n_state    = S_DIV;
                                n_is_eq    = (i_item.kind == K_EQ);
                                n_neg      = r_left[DATA_WIDTH-1] ^ r_num[DATA_WIDTH-1];
                                n_den_zero = (r_num == '0);
                                n_den      = num_mag;
                                n_quo      = left_mag;
                                n_rem      = '0;
                                n_cnt      = CNT_W'(DATA_WIDTH - 1);
                                n_op       = (i_item.kind == K_EQ) ? OP_NONE : i_item.op;
                                n_num      = '0;
                                n_started  = 1'b0;
                                n_ended    = 1'b0;
                            end else if (i_item.kind == K_OP) begin
                                o_pop     = 1'b1;
                                n_left    = apply_val;
                                n_op      = i_item.op;
                                n_num     = '0;
                                n_started = 1'b0;
                                n_ended   = 1'b0;
                            end else if (out_free) begin
                                o_pop        = 1'b1;
                                n_out_valid  = 1'b1;
                                n_out_result = to_result(apply_val);
                                n_left       = '0;
                                n_op         = OP_NONE;
                                n_num        = '0;
                                n_started    = 1'b0;
                                n_ended      = 1'b0;
                            end
                        end
                        default: begin
                            o_pop = 1'b1;
                        end
                    endcase
                end
            end
            S_DIV: begin
                // One restoring step per cycle.
                if (!diff[DATA_WIDTH]) begin
                    n_rem = diff[DATA_WIDTH-1:0];
                end else begin
                    n_rem = rem_sh[DATA_WIDTH-1:0];
                end
                n_quo = {r_quo[DATA_WIDTH-2:0], !diff[DATA_WIDTH]};
                if (r_cnt == '0) begin
                    n_state = S_FIX;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_FIX: begin
                n_left  = quo_fix;
                n_state = r_is_eq ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_result = to_result(r_left);
                    n_left       = '0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_neg        <= n_neg;
        r_den_zero   <= n_den_zero;
        r_rem        <= n_rem;
        r_quo        <= n_quo;
        r_den        <= n_den;
        r_cnt        <= n_cnt;
        r_out_result <= n_out_result;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_left      <= '0;
            r_num       <= '0;
            r_op        <= OP_NONE;
            r_started   <= 1'b0;
            r_ended     <= 1'b0;
            r_is_eq     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_left      <= n_left;
            r_num       <= n_num;
            r_op        <= n_op;
            r_started   <= n_started;
            r_ended     <= n_ended;
            r_is_eq     <= n_is_eq;
            r_out_valid <= n_out_valid;
        end
    end

    a_div_exit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |=> (r_state == S_DIV || r_state == S_FIX))
        else $error("divider left its loop early");

    a_pop_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == S_IDLE && !i_q_status.empty))
        else $error("item taken from queue outside idle or while empty");

    a_emit_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && r_out_valid && i_out_stall) |=> r_state == S_EMIT)
        else $error("pending result lost while output stalled");

    a_eq_clear : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_item.kind == K_EQ && r_op != OP_DIV)
        |=> (r_out_valid && r_op == OP_NONE && r_num == '0))
        else $error("equals did not give a result and clear state");

endmodule

// ----- tb/tb_left_to_right_expression_evaluator_top.sv -----
// Self-checking testbench for the left-to-right expression evaluator: it sends characters
// and equals commands, predicts each result in step with the block and compares them.
// Depends on lre_pkg and left_to_right_expression_evaluator_top.
module tb_left_to_right_expression_evaluator_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lre_pkg::*;

    // Stop the random phase once this many characters and commands have been sent.
    localparam int ITEM_TARGET   = 1440;
    // Generous margin over the worst case per item (divider, queue, stalls, gaps).
    localparam int CYCLE_LIMIT   = 600000;
    // A character gives no result, so let the back end finish a division after the last one.
    localparam int SETTLE_CYCLES = DATA_WIDTH + 8;
    localparam int RESET_CYCLES  = 11;
    localparam int REPORT_LIMIT  = 10;

    localparam logic [7:0] OPERATOR_CHARS [4] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};

    typedef logic signed [RESULT_WIDTH-1:0] t_result;

    logic       i_clk       = 1'b0;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic       i_cmd;
    logic [7:0] i_char_code;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_result    o_result;

    left_to_right_expression_evaluator_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_cmd       (i_cmd),
        .i_char_code (i_char_code),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (o_result)
    );

    // Shadow copy of the calculator state, updated as each item is accepted.
    t_value  calc_left;
    t_value  calc_number;
    t_op     calc_op;
    logic    calc_started;
    logic    calc_ended;

    // Results still owed by the block, oldest first.
    t_result expected_results [$];

    int      counted_items = 0;
    int      error_count   = 0;
    int      results_seen  = 0;
    int      cycle_count   = 0;
    int      burst_left    = 0;
    int      stall_mode    = 0;
    int      stall_span    = 0;

    // 2 ns clock.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver back-pressure: switch at random intervals between no stalls, light stalls,
    // heavy stalls and a regular on/off pattern.
    always @(posedge i_clk) begin
        if (stall_span == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_span <= $urandom_range(50, 300);
        end else begin
            stall_span <= stall_span - 1;
        end
        case (stall_mode)
            0:       i_out_stall <= 1'b0;
            1:       i_out_stall <= ($urandom_range(0, 3) == 0);
            2:       i_out_stall <= ($urandom_range(0, 3) != 0);
            default: i_out_stall <= cycle_count[2];
        endcase
    end

    // ---------------------------------------------------------------- prediction

    function automatic t_value signed_quotient(t_value dividend, t_value divisor);
        // Zero divisor gives zero; the one overflowing case wraps back to itself.
        if (divisor == '0) begin
            return '0;
        end
        if (dividend == {1'b1, {(DATA_WIDTH-1){1'b0}}} && divisor == '1) begin
            return dividend;
        end
        // Signed division in SystemVerilog truncates toward zero.
        return t_value'($signed(dividend) / $signed(divisor));
    endfunction

    function automatic t_value combine(t_value lhs, t_value rhs, t_op op);
        case (op)
            OP_ADD:  return lhs + rhs;
            OP_SUB:  return lhs - rhs;
            OP_MUL:  return lhs * rhs;
            OP_DIV:  return signed_quotient(lhs, rhs);
            default: return '0;
        endcase
    endfunction

    function automatic t_op operator_of(logic [7:0] ch);
        case (ch)
            CH_PLUS:  return OP_ADD;
            CH_MINUS: return OP_SUB;
            CH_STAR:  return OP_MUL;
            CH_SLASH: return OP_DIV;
            default:  return OP_NONE;
        endcase
    endfunction

    task automatic clear_number();
        calc_number  = '0;
        calc_started = 1'b0;
        calc_ended   = 1'b0;
    endtask

    // Advance the shadow calculator by one accepted item; queue a result on equals.
    task automatic predict_item(input logic cmd, input logic [7:0] ch);
        t_op    op;
        t_value total;
        op = operator_of(ch);
        counted_items++;
        if (cmd) begin
            total = (calc_op == OP_NONE) ? calc_number
                                         : combine(calc_left, calc_number, calc_op);
            expected_results.push_back(t_result'($signed(total)));
            calc_left = '0;
            calc_op   = OP_NONE;
            clear_number();
        end else if (op != OP_NONE) begin
            // First operator only loads the number; later ones fold it in.
            calc_left = (calc_op == OP_NONE) ? calc_number
                                             : combine(calc_left, calc_number, calc_op);
            calc_op   = op;
            clear_number();
        end else if (!calc_ended) begin
            if (ch >= CH_ZERO && ch <= CH_NINE) begin
                // Accumulate modulo 2^DATA_WIDTH, no length limit.
                calc_number  = calc_number * t_value'(10) + t_value'(ch - CH_ZERO);
                calc_started = 1'b1;
            end else if (!calc_started && (ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR))) begin
                // Skip leading whitespace.
            end else begin
                calc_ended = 1'b1;
            end
        end
        // Otherwise the digits are over: the character is dropped until the next operator.
    endtask

    // ---------------------------------------------------------------- result checking

    task automatic note_failure(input string what);
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
            $display("%s", what);
        end
    endtask

    // Sample at the falling edge: inputs and registered outputs are settled, and the
    // handshake seen here is the one taken at the next rising edge.
    always @(negedge i_clk) begin
        t_result want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (expected_results.size() == 0) begin
                note_failure($sformatf("Result %0d: nothing expected, got %0d (0x%08h)",
                                       results_seen, o_result, o_result));
            end else begin
                want = expected_results.pop_front();
                if (o_result !== want) begin
                    note_failure($sformatf("Result %0d: expected %0d (0x%08h), got %0d (0x%08h)",
                                           results_seen, want, want, o_result, o_result));
                end
            end
            results_seen++;
        end
    end

    // ---------------------------------------------------------------- stimulus

    // Send one item. Bursts of random length are separated by random idle gaps; some
    // bursts start with no gap so that long stretches run back to back.
    task automatic send_item(input logic cmd, input logic [7:0] ch);
        int   gap;
        logic taken;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid  <= 1'b1;
        i_cmd       <= cmd;
        i_char_code <= ch;
        // Hold the item until the block stops stalling.
        do begin
            @(negedge i_clk);
            taken = !o_in_stall;
            @(posedge i_clk);
        end while (!taken);
        predict_item(cmd, ch);
    endtask

    task automatic send_char(input logic [7:0] ch);
        send_item(1'b0, ch);
    endtask

    // The character code is ignored on equals, so let it toggle freely.
    task automatic send_equals();
        send_item(1'b1, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++) begin
            send_char(text[i]);
        end
    endtask

    task automatic send_digits(input int count);
        repeat (count) send_char(CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    task automatic send_operator();
        send_char(OPERATOR_CHARS[$urandom_range(0, 3)]);
    endtask

    task automatic send_whitespace();
        int pick;
        pick = $urandom_range(0, 5);
        send_char((pick == 0) ? CH_SPACE : CH_TAB + 8'(pick - 1));
    endtask

    // Pause the sender until every owed result is back, then let the back end go quiet.
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // A well-formed expression with random content: whitespace, numbers of varied length,
    // the odd empty number or trailing junk, then equals.
    task automatic send_expression();
        int terms;
        int pick;
        terms = $urandom_range(1, 5);
        for (int t = 0; t < terms; t++) begin
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 2)) send_whitespace();
            end
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                // empty number
            end else if (pick < 85) begin
                send_digits($urandom_range(1, 3));
            end else begin
                send_digits($urandom_range(4, 12));
            end
            if ($urandom_range(0, 9) == 0) begin
                if ($urandom_range(0, 1) == 0) begin
                    send_whitespace();
                end else begin
                    send_char(8'($urandom_range(0, 255)));
                end
                if ($urandom_range(0, 1) == 0) begin
                    send_digits($urandom_range(1, 3));
                end
            end
            if (t < terms - 1) begin
                send_operator();
            end
        end
        send_equals();
    endtask

    // Corner cases with random surroundings.
    task automatic send_special_case();
        case ($urandom_range(0, 3))
            0: begin
                // Most negative value over minus one.
                if ($urandom_range(0, 1) == 0) begin
                    send_text("00");
                end
                send_text("2147483648/4294967295");
                send_equals();
            end
            1: begin
                // Numbers long enough to wrap.
                send_digits($urandom_range(11, 20));
                if ($urandom_range(0, 1) == 0) begin
                    send_operator();
                    send_digits($urandom_range(11, 20));
                end
                send_equals();
            end
            2: begin
                // Division by zero, the zero possibly spelt with several digits.
                send_digits($urandom_range(1, 6));
                send_char(CH_SLASH);
                repeat ($urandom_range(1, 3)) send_char(CH_ZERO);
                send_equals();
            end
            default: begin
                // Equals on nothing, or on whitespace only.
                if ($urandom_range(0, 1) == 0) begin
                    send_whitespace();
                end
                send_equals();
            end
        endcase
    endtask

    // Arbitrary codes, sometimes closed by equals and sometimes running into the next
    // expression as a broken prefix.
    task automatic send_noise();
        repeat ($urandom_range(1, 10)) send_char(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 9) < 6) begin
            send_equals();
        end
    endtask

    // ---------------------------------------------------------------- tests

    // Equals with nothing entered gives zero.
    task automatic test_empty_equals();
        send_equals();
    endtask

    // Leading tab skipped, code zero ends the number, an empty number between two
    // operators counts as zero, then subtract and multiply: (9 + 0 - 3) * 2 = 12.
    task automatic test_separators_and_operators();
        send_char(CH_TAB);
        send_text("9");
        send_char(8'h00);
        send_text("+-3*2");
        send_equals();
    endtask

    // Negative quotient truncates toward zero: (1 - 8) / 3 = -2, with code 255 ending
    // the 8. Then division by zero.
    task automatic test_truncating_division();
        send_text("1-8");
        send_char(8'hFF);
        send_text("/3");
        send_equals();
        send_text("5/0");
        send_equals();
    endtask

    // Mostly well-formed expressions, some corner cases and noise, with the odd full
    // drain of the pipeline along the way.
    task automatic test_random_expressions();
        int pick;
        while (counted_items < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                send_expression();
            end else if (pick < 87) begin
                send_special_case();
            end else begin
                send_noise();
            end
            if ($urandom_range(0, 49) == 0) begin
                wait_for_results();
            end
        end
        // Close any broken prefix left by noise so its state is checked too.
        send_equals();
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_cmd       <= 1'b0;
        i_char_code <= 8'h00;
        calc_left   = '0;
        calc_op     = OP_NONE;
        clear_number();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_equals();
        test_separators_and_operators();
        test_truncating_division();
        // Drain completely before the random phase.
        wait_for_results();
        test_random_expressions();
        wait_for_results();

        if (error_count == 0 && expected_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
